>>> rtl/core/m_of_n_pulse_integrator_macros.svh
// Assertion macros shared by the checker of the M-of-N pulse integrator.
`ifndef M_OF_N_PULSE_INTEGRATOR_MACROS_SVH
`define M_OF_N_PULSE_INTEGRATOR_MACROS_SVH

// A clocked property that is checked outside of reset.
`define MNPI_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition that must imply a consequence in the same cycle.
`define MNPI_ASSERT_IMPLY(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// A condition that must imply a consequence in the following cycle.
`define MNPI_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

>>> rtl/core/mnpi_pkg.sv
// Package with the types and constants of the M-of-N pulse integrator.
`default_nettype none

package mnpi_pkg;

    localparam int MAX_BINS            = 4096;
    localparam int MAX_PULSES          = 256;
    localparam int FIRST_COUNTED_PULSE = 2;

    localparam int BIN_W    = $clog2(MAX_BINS);
    localparam int POS_W    = BIN_W + 1;
    localparam int PULSE_W  = $clog2(MAX_PULSES);
    localparam int CFG_W    = 9;
    localparam int COUNT_W  = 8;
    localparam int SPAN_W   = CFG_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSES_PER_INTERVAL = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_HIT_THRESHOLD       = CFG_INDEX_W'(1);

    localparam logic [CFG_W-1:0] PULSES_PER_INTERVAL_RESET = CFG_W'(16);
    localparam logic [CFG_W-1:0] HIT_THRESHOLD_RESET       = CFG_W'(3);

    localparam int OPQ_DEPTH   = 4;
    localparam int OPQ_PTR_W   = $clog2(OPQ_DEPTH);
    localparam int OPQ_CNT_W   = $clog2(OPQ_DEPTH + 1);
    localparam int OUTQ_DEPTH  = 4;
    localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic             clear;
        logic             incr;
        logic             emit;
        logic             last;
    } op_t;

    typedef struct packed {
        logic             detected;
        logic [BIN_W-1:0] bin;
        logic             last;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/m_of_n_pulse_integrator.sv
// Top level of the M-of-N binary pulse integrator.
//
// Samples of binary radar video enter through a queue-like port: an item is
// taken when push is high and full is low, and carries hit, pulse_end and
// interval_start for one range bin. Decisions leave through a second
// queue-like port: while empty is low the oldest decision is on detected,
// bin_index and last_bin, and pop takes it. Only samples of the final pulse
// of an interval produce a decision. The configuration channel writes
// pulses_per_interval and hit_threshold and is always ready.
// One item is taken per cycle while full is low. A decision reaches the
// result port after its item has passed the operation queue, the registered
// read of the per-bin counter memory and the update stage.
// When pop stays low the four-entry result queue fills, then the four-entry
// operation queue, and then full rises until results are taken again.
// Reset zeroes the pulse and range position, empties both queues and loads
// the default configuration; the counters are not cleared, since pulse 0 of
// every interval rewrites each bin it covers.
`default_nettype none

module m_of_n_pulse_integrator (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic                             hit,
    input  wire logic                             pulse_end,
    input  wire logic                             interval_start,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic                                  detected,
    output logic [mnpi_pkg::BIN_W-1:0]            bin_index,
    output logic                                  last_bin,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mnpi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mnpi_pkg::CFG_W-1:0]       cfg_data
);

    logic [mnpi_pkg::CFG_W-1:0] span_cfg_reg;
    logic [mnpi_pkg::CFG_W-1:0] span_cfg_next;
    logic [mnpi_pkg::CFG_W-1:0] thr_cfg_reg;
    logic [mnpi_pkg::CFG_W-1:0] thr_cfg_next;

    logic                       op_push;
    mnpi_pkg::op_t              front_op;
    logic                       q_full;
    logic                       q_empty;
    logic                       q_pop;
    mnpi_pkg::op_t              q_head;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    always_comb
    begin
        span_cfg_next = span_cfg_reg;
        thr_cfg_next  = thr_cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mnpi_pkg::REG_PULSES_PER_INTERVAL: span_cfg_next = cfg_data;
                mnpi_pkg::REG_HIT_THRESHOLD:       thr_cfg_next  = cfg_data;
                default:                           span_cfg_next = span_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_cfg_reg <= mnpi_pkg::PULSES_PER_INTERVAL_RESET;
            thr_cfg_reg  <= mnpi_pkg::HIT_THRESHOLD_RESET;
        end
        else
        begin
            span_cfg_reg <= span_cfg_next;
            thr_cfg_reg  <= thr_cfg_next;
        end
    end

    mnpi_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .push                (push),
        .hit                 (hit),
        .pulse_end           (pulse_end),
        .interval_start      (interval_start),
        .pulses_per_interval (span_cfg_reg),
        .q_full              (q_full),
        .op_push             (op_push),
        .op                  (front_op)
    );

    mnpi_op_queue u_op_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (op_push),
        .wr_op (front_op),
        .full  (q_full),
        .rd_en (q_pop),
        .rd_op (q_head),
        .empty (q_empty)
    );

    mnpi_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .op_valid      (!q_empty),
        .op_head       (q_head),
        .op_pop        (q_pop),
        .hit_threshold (thr_cfg_reg),
        .pop           (pop),
        .empty         (empty),
        .detected      (detected),
        .bin_index     (bin_index),
        .last_bin      (last_bin)
    );

endmodule

`default_nettype wire

>>> rtl/core/mnpi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mnpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mnpi_front.sv
// Front part: tracks pulse and range position and turns samples into counter operations.
`default_nettype none

module mnpi_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire logic                      hit,
    input  wire logic                      pulse_end,
    input  wire logic                      interval_start,
    input  wire logic [mnpi_pkg::CFG_W-1:0] pulses_per_interval,
    input  wire logic                      q_full,
    output logic                           op_push,
    output mnpi_pkg::op_t                  op
);

    logic [mnpi_pkg::PULSE_W-1:0] pulse_reg;
    logic [mnpi_pkg::PULSE_W-1:0] pulse_next;
    logic [mnpi_pkg::POS_W-1:0]   pos_reg;
    logic [mnpi_pkg::POS_W-1:0]   pos_next;

    logic                          accept;
    logic [mnpi_pkg::CFG_W-1:0]    span;
    logic [mnpi_pkg::SPAN_W-1:0]   span_ext;
    logic [mnpi_pkg::PULSE_W-1:0]  pulse_cur;
    logic [mnpi_pkg::SPAN_W-1:0]   pulse_ext;
    logic [mnpi_pkg::POS_W-1:0]    pos_cur;
    logic                          in_range;
    logic                          is_final;
    logic                          counted;

    assign accept = push && !q_full;

    always_comb
    begin
        if (pulses_per_interval == '0)
        begin
            span = mnpi_pkg::CFG_W'(1);
        end
        else if (pulses_per_interval > mnpi_pkg::CFG_W'(mnpi_pkg::MAX_PULSES))
        begin
            span = mnpi_pkg::CFG_W'(mnpi_pkg::MAX_PULSES);
        end
        else
        begin
            span = pulses_per_interval;
        end
    end

    assign span_ext  = mnpi_pkg::SPAN_W'(span);
    assign pulse_cur = interval_start ? '0 : pulse_reg;
    assign pos_cur   = interval_start ? '0 : pos_reg;
    assign pulse_ext = mnpi_pkg::SPAN_W'(pulse_cur);
    assign in_range  = pos_cur < mnpi_pkg::POS_W'(mnpi_pkg::MAX_BINS);
    assign is_final  = (pulse_ext + mnpi_pkg::SPAN_W'(1)) == span_ext;
    assign counted   = (pulse_cur >= mnpi_pkg::PULSE_W'(mnpi_pkg::FIRST_COUNTED_PULSE))
                    && ((pulse_ext + mnpi_pkg::SPAN_W'(2)) <= span_ext);

    always_comb
    begin
        op.bin   = pos_cur[mnpi_pkg::BIN_W-1:0];
        op.clear = pulse_cur == '0;
        op.incr  = counted && hit;
        op.emit  = is_final;
        op.last  = pulse_end;
        op_push  = accept && in_range && (op.clear || op.incr || op.emit);
    end

    always_comb
    begin
        pulse_next = pulse_reg;
        pos_next   = pos_reg;
        if (accept)
        begin
            pulse_next = pulse_cur;
            pos_next   = in_range ? pos_cur + mnpi_pkg::POS_W'(1) : pos_cur;
            if (pulse_end)
            begin
                pos_next = '0;
                if ((pulse_ext + mnpi_pkg::SPAN_W'(1)) >= span_ext)
                begin
                    pulse_next = '0;
                end
                else
                begin
                    pulse_next = pulse_cur + mnpi_pkg::PULSE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            pulse_reg <= pulse_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mnpi_op_queue.sv
// Short queue of counter operations between the front and back parts.
`default_nettype none

module mnpi_op_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire mnpi_pkg::op_t wr_op,
    output logic               full,
    input  wire logic          rd_en,
    output mnpi_pkg::op_t      rd_op,
    output logic               empty
);

    mnpi_pkg::op_t                  entry_reg [mnpi_pkg::OPQ_DEPTH];
    logic [mnpi_pkg::OPQ_PTR_W-1:0] wr_ptr_reg;
    logic [mnpi_pkg::OPQ_PTR_W-1:0] wr_ptr_next;
    logic [mnpi_pkg::OPQ_PTR_W-1:0] rd_ptr_reg;
    logic [mnpi_pkg::OPQ_PTR_W-1:0] rd_ptr_next;
    logic [mnpi_pkg::OPQ_CNT_W-1:0] count_reg;
    logic [mnpi_pkg::OPQ_CNT_W-1:0] count_next;
    logic                           do_wr;
    logic                           do_rd;

    assign full  = count_reg == mnpi_pkg::OPQ_CNT_W'(mnpi_pkg::OPQ_DEPTH);
    assign empty = count_reg == '0;
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_op = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + mnpi_pkg::OPQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + mnpi_pkg::OPQ_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + mnpi_pkg::OPQ_CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - mnpi_pkg::OPQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mnpi_back.sv
// Back part: counter memory read-modify-write, threshold decision and result queue.
`default_nettype none

module mnpi_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       op_valid,
    input  wire mnpi_pkg::op_t              op_head,
    output logic                            op_pop,
    input  wire logic [mnpi_pkg::CFG_W-1:0] hit_threshold,
    input  wire logic                       pop,
    output logic                            empty,
    output logic                            detected,
    output logic [mnpi_pkg::BIN_W-1:0]      bin_index,
    output logic                            last_bin
);

    mnpi_pkg::op_t                   b_op_reg;
    logic                            b_valid_reg;
    logic                            b_valid_next;
    logic                            wr_valid_reg;
    logic                            wr_valid_next;
    logic [mnpi_pkg::BIN_W-1:0]      wr_addr_reg;
    logic [mnpi_pkg::COUNT_W-1:0]    wr_data_reg;

    logic [mnpi_pkg::COUNT_W-1:0]    ram_rdata;
    logic [mnpi_pkg::COUNT_W-1:0]    base_count;
    logic [mnpi_pkg::COUNT_W-1:0]    new_count;
    logic                            ram_we;
    logic                            res_push;
    mnpi_pkg::result_t               res_in;

    mnpi_pkg::result_t               outq_reg [mnpi_pkg::OUTQ_DEPTH];
    logic [mnpi_pkg::OUTQ_PTR_W-1:0] oq_wr_ptr_reg;
    logic [mnpi_pkg::OUTQ_PTR_W-1:0] oq_wr_ptr_next;
    logic [mnpi_pkg::OUTQ_PTR_W-1:0] oq_rd_ptr_reg;
    logic [mnpi_pkg::OUTQ_PTR_W-1:0] oq_rd_ptr_next;
    logic [mnpi_pkg::OUTQ_CNT_W-1:0] oq_count_reg;
    logic [mnpi_pkg::OUTQ_CNT_W-1:0] oq_count_next;
    logic [mnpi_pkg::OUTQ_CNT_W:0]   oq_committed;
    logic                            res_pop;

    // The stage is never stalled, so an operation only leaves the queue when its result fits.
    assign oq_committed = (mnpi_pkg::OUTQ_CNT_W + 1)'(oq_count_reg)
                        + (mnpi_pkg::OUTQ_CNT_W + 1)'(b_valid_reg);
    assign op_pop = op_valid
                 && (oq_committed < (mnpi_pkg::OUTQ_CNT_W + 1)'(mnpi_pkg::OUTQ_DEPTH));

    mnpi_ram #(
        .WIDTH (mnpi_pkg::COUNT_W),
        .DEPTH (mnpi_pkg::MAX_BINS)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (b_op_reg.bin),
        .wdata (new_count),
        .re    (op_pop),
        .raddr (op_head.bin),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (b_op_reg.clear)
        begin
            base_count = '0;
        end
        else if (wr_valid_reg && (wr_addr_reg == b_op_reg.bin))
        begin
            base_count = wr_data_reg;
        end
        else
        begin
            base_count = ram_rdata;
        end
        new_count = base_count;
        if (b_op_reg.incr && (base_count != mnpi_pkg::COUNT_MAX))
        begin
            new_count = base_count + mnpi_pkg::COUNT_W'(1);
        end
        ram_we          = b_valid_reg && (b_op_reg.clear || b_op_reg.incr);
        res_push        = b_valid_reg && b_op_reg.emit;
        res_in.detected = mnpi_pkg::CFG_W'(new_count) >= hit_threshold;
        res_in.bin      = b_op_reg.bin;
        res_in.last     = b_op_reg.last;
        b_valid_next    = op_pop;
        wr_valid_next   = wr_valid_reg || ram_we;
    end

    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            b_op_reg <= op_head;
        end
        if (ram_we)
        begin
            wr_addr_reg <= b_op_reg.bin;
            wr_data_reg <= new_count;
        end
        if (res_push)
        begin
            outq_reg[oq_wr_ptr_reg] <= res_in;
        end
    end

    assign empty     = oq_count_reg == '0;
    assign res_pop   = pop && !empty;
    assign detected  = outq_reg[oq_rd_ptr_reg].detected;
    assign bin_index = outq_reg[oq_rd_ptr_reg].bin;
    assign last_bin  = outq_reg[oq_rd_ptr_reg].last;

    always_comb
    begin
        oq_wr_ptr_next = res_push ? oq_wr_ptr_reg + mnpi_pkg::OUTQ_PTR_W'(1) : oq_wr_ptr_reg;
        oq_rd_ptr_next = res_pop ? oq_rd_ptr_reg + mnpi_pkg::OUTQ_PTR_W'(1) : oq_rd_ptr_reg;
        oq_count_next  = oq_count_reg;
        if (res_push && !res_pop)
        begin
            oq_count_next = oq_count_reg + mnpi_pkg::OUTQ_CNT_W'(1);
        end
        else if (res_pop && !res_push)
        begin
            oq_count_next = oq_count_reg - mnpi_pkg::OUTQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            wr_valid_reg  <= 1'b0;
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_count_reg  <= '0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            wr_valid_reg  <= wr_valid_next;
            oq_wr_ptr_reg <= oq_wr_ptr_next;
            oq_rd_ptr_reg <= oq_rd_ptr_next;
            oq_count_reg  <= oq_count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mnpi_checker.sv
// Port-level checker for the M-of-N pulse integrator and its bind statement.
`default_nettype none

`include "m_of_n_pulse_integrator_macros.svh"

module mnpi_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             full,
    input  wire logic                             empty,
    input  wire logic                             pop,
    input  wire logic                             detected,
    input  wire logic [mnpi_pkg::BIN_W-1:0]       bin_index,
    input  wire logic                             last_bin,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [mnpi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mnpi_pkg::CFG_W-1:0]       cfg_data
);

    logic [mnpi_pkg::CFG_W-1:0]   thr_reg;
    logic [mnpi_pkg::CFG_W-1:0]   thr_next;
    logic                         thr_zero;
    logic                         thr_high;
    logic [mnpi_pkg::BIN_W+1:0]   res_word;

    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_valid && cfg_ready && (cfg_index == mnpi_pkg::REG_HIT_THRESHOLD))
        begin
            thr_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= mnpi_pkg::HIT_THRESHOLD_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign thr_zero = thr_reg == '0;
    assign thr_high = thr_reg > mnpi_pkg::CFG_W'(mnpi_pkg::COUNT_MAX);
    assign res_word = {detected, bin_index, last_bin};

    // A waiting result must stay in place until it is taken.
    `MNPI_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(res_word), "result changed")

    `MNPI_ASSERT_IMPLY(a_zero_threshold, !empty && thr_zero, detected, "zero threshold missed a bin")

    `MNPI_ASSERT_IMPLY(a_high_threshold, !empty && thr_high, !detected, "unreachable threshold hit")

    `MNPI_ASSERT_CLK(a_flags_known, !$isunknown({full, empty, cfg_ready}), "handshake flag unknown")

endmodule

bind m_of_n_pulse_integrator mnpi_checker u_mnpi_checker (.*);

`default_nettype wire

>>> test/m_of_n_pulse_integrator_tb.sv
// Self-checking testbench for the M-of-N pulse integrator, directed cases then random traffic.
`timescale 1ns / 1ps

module m_of_n_pulse_integrator_tb;

    import mnpi_pkg::*;

    localparam int     SETTLE_CYCLES = 8;
    localparam longint TIMEOUT_NS    = 8_000_000;

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   push           = 1'b0;
    logic                   full;
    logic                   hit            = 1'b0;
    logic                   pulse_end      = 1'b0;
    logic                   interval_start = 1'b0;
    logic                   empty;
    logic                   pop            = 1'b0;
    logic                   detected;
    logic [BIN_W-1:0]       bin_index;
    logic                   last_bin;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index      = REG_PULSES_PER_INTERVAL;
    logic [CFG_W-1:0]       cfg_data       = '0;

    logic [CFG_W-1:0]   span_reg  = PULSES_PER_INTERVAL_RESET;
    logic [CFG_W-1:0]   thr_reg   = HIT_THRESHOLD_RESET;
    logic [COUNT_W-1:0] bin_counts [MAX_BINS];
    logic [PULSE_W-1:0] pulse_no  = '0;
    logic [POS_W-1:0]   range_pos = '0;
    int                 written_len = 0;
    result_t            pending_decisions [$];

    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;
    int samples_sent      = 0;
    int decisions_checked = 0;
    int reg_writes        = 0;
    int error_count       = 0;

    m_of_n_pulse_integrator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .hit            (hit),
        .pulse_end      (pulse_end),
        .interval_start (interval_start),
        .empty          (empty),
        .pop            (pop),
        .detected       (detected),
        .bin_index      (bin_index),
        .last_bin       (last_bin),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("m_of_n_pulse_integrator regression: fail");
        $finish;
    end

    task automatic report_mismatch(string what);
        $display("ERROR @%0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic int effective_span();
        if (span_reg == '0)
            return 1;
        if (int'(span_reg) > MAX_PULSES)
            return MAX_PULSES;
        return int'(span_reg);
    endfunction

    function automatic void integrate_sample(logic h, logic pe, logic st);
        int               span;
        logic [BIN_W-1:0] idx;
        result_t          res;
        span = effective_span();
        if (st)
        begin
            pulse_no  = '0;
            range_pos = '0;
        end
        if (int'(range_pos) < MAX_BINS)
        begin
            idx = range_pos[BIN_W-1:0];
            if (pulse_no == '0)
            begin
                bin_counts[idx] = '0;
                if (int'(range_pos) >= written_len)
                    written_len = int'(range_pos) + 1;
            end
            if (int'(pulse_no) >= FIRST_COUNTED_PULSE && int'(pulse_no) + 2 <= span && h
                && bin_counts[idx] != COUNT_MAX)
                bin_counts[idx] = bin_counts[idx] + 1'b1;
            if (int'(pulse_no) + 1 == span)
            begin
                res.detected = (int'(bin_counts[idx]) >= int'(thr_reg));
                res.bin      = idx;
                res.last     = pe;
                pending_decisions = {pending_decisions, res};
            end
            range_pos = range_pos + 1'b1;
        end
        if (pe)
        begin
            range_pos = '0;
            if (int'(pulse_no) + 1 >= span)
                pulse_no = '0;
            else
                pulse_no = pulse_no + 1'b1;
        end
    endfunction

    // A sample past pulse 0 must never land on a counter that was never cleared,
    // so such a sample is turned into the start of a new interval.
    task automatic send_sample(logic h, logic pe, logic st);
        if (!st && pulse_no != '0 && int'(range_pos) < MAX_BINS
            && int'(range_pos) >= written_len)
            st = 1'b1;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push           <= 1'b1;
        hit            <= h;
        pulse_end      <= pe;
        interval_start <= st;
        do
            @(posedge clk);
        while (full);
        integrate_sample(h, pe, st);
        samples_sent++;
    endtask

    task automatic wait_for_decisions();
        push <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
        wait_for_decisions();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_PULSES_PER_INTERVAL)
            span_reg = val;
        else
            thr_reg = val;
        reg_writes++;
    endtask

    initial
    begin : decision_checker
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                decisions_checked++;
                if (pending_decisions.size() == 0)
                    report_mismatch($sformatf("decision for bin %0d with none expected",
                                              bin_index));
                else
                begin
                    want = pending_decisions.pop_front();
                    if (detected !== want.detected)
                        report_mismatch($sformatf("bin %0d: detected %b, expected %b",
                                                  want.bin, detected, want.detected));
                    if (bin_index !== want.bin)
                        report_mismatch($sformatf("bin_index %0d, expected %0d",
                                                  bin_index, want.bin));
                    if (last_bin !== want.last)
                        report_mismatch($sformatf("bin %0d: last_bin %b, expected %b",
                                                  want.bin, last_bin, want.last));
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic test_reset_defaults();
        for (int p = 0; p < 16; p++)
            send_sample(p <= 4 || p == 15, 1'b1, 1'b0);
    endtask

    task automatic test_threshold_extremes();
        write_reg(REG_PULSES_PER_INTERVAL, CFG_W'(0));
        write_reg(REG_HIT_THRESHOLD, CFG_W'(0));
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b0, 1'b1, 1'b0);
        write_reg(REG_HIT_THRESHOLD, CFG_W'(511));
        send_sample(1'b1, 1'b1, 1'b0);
        write_reg(REG_HIT_THRESHOLD, CFG_W'(256));
        send_sample(1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_interval_restart();
        write_reg(REG_PULSES_PER_INTERVAL, CFG_W'(4));
        write_reg(REG_HIT_THRESHOLD, CFG_W'(0));
        send_sample(1'b0, 1'b1, 1'b1);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b0, 1'b1, 1'b1);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_longer_later_pulse();
        write_reg(REG_HIT_THRESHOLD, CFG_W'(1));
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b0, 1'b0, 1'b0);
        send_sample(1'b1, 1'b1, 1'b0);
    endtask

    task automatic randomize_config();
        logic [CFG_W-1:0] span_val;
        logic [CFG_W-1:0] thr_val;
        case ($urandom_range(9))
            0:       span_val = CFG_W'(0);
            1:       span_val = CFG_W'(1);
            2:       span_val = CFG_W'(2);
            3:       span_val = CFG_W'(3);
            7:       span_val = CFG_W'(16);
            8:       span_val = CFG_W'(MAX_PULSES);
            9:       span_val = CFG_W'($urandom_range(MAX_PULSES + 1, 511));
            default: span_val = CFG_W'($urandom_range(4, 10));
        endcase
        write_reg(REG_PULSES_PER_INTERVAL, span_val);
        case ($urandom_range(9))
            0:       thr_val = CFG_W'(0);
            1:       thr_val = CFG_W'(1);
            2:       thr_val = CFG_W'($urandom_range(2, effective_span()));
            3:       thr_val = CFG_W'(256);
            4:       thr_val = CFG_W'(511);
            5:       thr_val = CFG_W'($urandom_range(0, 511));
            default: thr_val = CFG_W'($urandom_range(1, 4));
        endcase
        write_reg(REG_HIT_THRESHOLD, thr_val);
    endtask

    task automatic send_random_interval();
        int  span;
        int  base;
        int  len;
        int  hit_pct;
        int  abort_at;
        int  sent;
        bit  with_start;
        span       = effective_span();
        base       = (span > 16) ? 1 : $urandom_range(1, 6);
        hit_pct    = $urandom_range(10, 90);
        with_start = ($urandom_range(9) < 8);
        abort_at   = ($urandom_range(9) == 0) ? $urandom_range(0, span * base) : -1;
        sent       = 0;
        for (int p = 0; p < span; p++)
        begin
            len = base;
            if (p > 0 && $urandom_range(3) == 0)
                len = base + $urandom_range(0, 3);
            if (p > 0 && len > written_len)
                len = written_len;
            for (int b = 0; b < len; b++)
            begin
                if (sent == abort_at)
                    return;
                send_sample($urandom_range(99) < hit_pct, b == len - 1,
                            with_start && p == 0 && b == 0);
                sent++;
            end
        end
    endtask

    task automatic send_noise_burst();
        int n;
        n = $urandom_range(1, 10);
        repeat (n)
            send_sample(1'($urandom_range(1)), $urandom_range(3) == 0,
                        $urandom_range(9) == 0);
    endtask

    task automatic test_random_traffic(int n_samples, int send_pct, int recv_pct);
        int first;
        int next_reconfig;
        bit paused;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first         = samples_sent;
        next_reconfig = samples_sent;
        paused        = 1'b0;
        while (samples_sent - first < n_samples)
        begin
            if (samples_sent >= next_reconfig)
            begin
                randomize_config();
                next_reconfig = samples_sent + $urandom_range(80, 200);
            end
            if (!paused && samples_sent - first > n_samples / 2)
            begin
                wait_for_decisions();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 80)
                send_random_interval();
            else
                send_noise_burst();
        end
    endtask

    initial
    begin
        for (int i = 0; i < MAX_BINS; i++)
            bin_counts[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_threshold_extremes();
        test_interval_restart();
        test_longer_later_pulse();
        test_random_traffic(630, 15, 81);
        test_random_traffic(630, 81, 15);
        test_random_traffic(640, 0, 0);

        wait_for_decisions();
        $display("Sent %0d samples, checked %0d decisions, made %0d register writes.",
                 samples_sent, decisions_checked, reg_writes);
        $display("Spans 0 to 511 and thresholds 0 to 511 were used, with restarts and aborts.");
        if (error_count == 0)
            $display("m_of_n_pulse_integrator regression: pass");
        else
            $display("m_of_n_pulse_integrator regression: fail");
        $finish;
    end

endmodule

>>> m_of_n_pulse_integrator.f
+incdir+rtl/core
rtl/core/mnpi_pkg.sv
rtl/core/mnpi_ram.sv
rtl/core/mnpi_front.sv
rtl/core/mnpi_op_queue.sv
rtl/core/mnpi_back.sv
rtl/core/m_of_n_pulse_integrator.sv
rtl/core/mnpi_checker.sv
test/m_of_n_pulse_integrator_tb.sv
